/* rtl/tcbcc_pkg.sv */
// ============================================================================
// tcbcc_pkg: shared types and helpers of the timecode continuity checker
// Word layouts, configuration register indexes, BCD and modulo helpers.
// ============================================================================
`default_nettype none

package tcbcc_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAMES_PER_SECOND = 1'b0,
        CFG_DROP_NUMBERING    = 1'b1
    } cfg_index_t;

    localparam logic [5:0] FPS_RESET        = 6'd25;
    localparam logic [5:0] FIELD_SECOND_FPS = 6'd59;
    localparam logic [5:0] FIELD_HOUR_FPS   = 6'd49;

    // Tens digit masks of the pack bytes.
    localparam logic [7:0] HOUR_TENS_MASK   = 8'h30;
    localparam logic [7:0] MINUTE_TENS_MASK = 8'h70;
    localparam logic [7:0] SECOND_TENS_MASK = 8'h70;
    localparam logic [7:0] FRAME_TENS_MASK  = 8'h30;
    localparam logic [7:0] DAY_TENS_MASK    = 8'h30;
    localparam logic [7:0] MONTH_TENS_MASK  = 8'h10;
    localparam logic [7:0] YEAR_TENS_MASK   = 8'hF0;

    localparam int DROP_FLAG_BIT = 6;
    localparam int FIELD_BIT_POS = 7;

    localparam logic [7:0] LAST_SECOND    = 8'd59;
    localparam logic [7:0] LAST_MINUTE    = 8'd59;
    localparam logic [6:0] HOURS_PER_DAY  = 7'd24;
    localparam logic [6:0] DROP_TO_FRAME  = 7'd2;

    typedef struct packed {
        logic       new_sequence;
        logic [7:0] frame_byte;
        logic [7:0] second_byte;
        logic [7:0] minute_byte;
        logic [7:0] hour_byte;
        logic [7:0] day_byte;
        logic [7:0] month_byte;
        logic [7:0] year_byte;
    } tcbcc_in_t;

    typedef struct packed {
        logic [5:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic [5:0] frames;
        logic       drop_flag;
        logic       field_bit;
        logic [6:0] full_frame;
        logic [5:0] day;
        logic [4:0] month;
        logic [7:0] year;
        logic       continuity_ok;
        logic       sequence_failed;
    } tcbcc_out_t;

    // Decoded time of day of one pack.
    typedef struct packed {
        logic [5:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic [5:0] frames;
    } tcbcc_time_t;

    // Everything the decoder derives from one pack.
    typedef struct packed {
        tcbcc_time_t tm;
        logic        drop_flag;
        logic        field_bit;
        logic [6:0]  full_frame;
        logic [5:0]  day;
        logic [4:0]  month;
        logic [7:0]  year;
    } tcbcc_dec_t;

    // Tens digit under a mask, times ten, plus the units nibble.
    function automatic logic [7:0] bcd_value(input logic [7:0] b, input logic [7:0] mask);
        logic [7:0] masked;
        logic [3:0] tens;
        begin
            masked = b & mask;
            tens   = masked[7:4];
            return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'h0, b[3:0]};
        end
    endfunction

    // True when a value below 128 is not a multiple of ten.
    // The quotient comes from a multiply by 205/2048, exact for this range.
    function automatic logic not_tenth(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  tenq;
        begin
            prod = {8'd0, v} * 15'd205;
            q    = prod[14:11];
            tenq = {q, 3'b000} + {2'b00, q, 1'b0};
            return v != tenq;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/timecode_bcd_continuity_checker_unit.sv */
// ============================================================================
// timecode_bcd_continuity_checker_unit: timecode pack decoder and checker
// Decodes BCD timecode packs and checks that each follows the one before.
// ============================================================================
// Usage: a source presents one seven-byte timecode pack per word on the pack
// channel (pack_valid, pack_stall, pack). Each accepted word gives exactly one
// result word on the result channel (result_valid, result_stall, result) with
// the decoded time, field, date, the continuity verdict and the sticky
// failure flag. A word is taken at a rising edge with valid high and stall
// low on its channel.
// The pack is captured in an input register, then decoded and checked in one
// pass of short logic into the result register. Throughput is one word per
// cycle while the receiver does not stall; the continuity state updates at
// the same edge that loads the result register, so the next pack is already
// compared against it.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more pack; only then is pack_stall raised.
// Reset clears both registers' valid bits, the continuity history and the
// failure flag, and loads frames_per_second with 25 and drop_numbering with 0.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must do so only while no words are in flight; the block does not enforce it.
// ============================================================================
`default_nettype none

module timecode_bcd_continuity_checker_unit
    import tcbcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   pack_valid,
    output logic                   pack_stall,
    input  tcbcc_in_t              pack,

    output logic                   result_valid,
    input  logic                   result_stall,
    output tcbcc_out_t             result,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [5:0] fps_reg;
    logic       drop_reg;

    // Input register.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    tcbcc_in_t  s1_pack_reg;

    // Result register.
    logic       result_valid_reg;
    logic       result_valid_next;
    tcbcc_out_t result_reg;
    tcbcc_out_t result_next;

    logic       pack_take;
    logic       result_free;
    logic       advance;

    tcbcc_dec_t dec;
    logic       check_ok;
    logic       check_failed;

    // The result register is free when empty or when its word leaves now.
    assign result_free = !result_valid_reg || !result_stall;
    assign advance     = s1_valid_reg && result_free;
    assign pack_stall  = s1_valid_reg && !result_free;
    assign pack_take   = pack_valid && !pack_stall;

    assign s1_valid_next     = pack_take || (s1_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg  <= FPS_RESET;
            drop_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_FRAMES_PER_SECOND)
            begin
                fps_reg <= cfg_data;
            end
            else if (cfg_index == CFG_DROP_NUMBERING)
            begin
                drop_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers load only on a transfer, so a stalled word holds.
    always_ff @(posedge clk)
    begin
        if (pack_take)
        begin
            s1_pack_reg <= pack;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    tcbcc_decode u_decode (
        .pack (s1_pack_reg),
        .fps  (fps_reg),
        .dec  (dec)
    );

    // History advances only when the word moves into the result register.
    tcbcc_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .start          (s1_pack_reg.new_sequence),
        .tm             (dec.tm),
        .fps            (fps_reg),
        .drop_numbering (drop_reg),
        .ok             (check_ok),
        .failed         (check_failed)
    );

    always_comb
    begin
        result_next.hours           = dec.tm.hours;
        result_next.minutes         = dec.tm.minutes;
        result_next.seconds         = dec.tm.seconds;
        result_next.frames          = dec.tm.frames;
        result_next.drop_flag       = dec.drop_flag;
        result_next.field_bit       = dec.field_bit;
        result_next.full_frame      = dec.full_frame;
        result_next.day             = dec.day;
        result_next.month           = dec.month;
        result_next.year            = dec.year;
        result_next.continuity_ok   = check_ok;
        result_next.sequence_failed = check_failed;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // A reported break always shows up in the sticky flag of the same word.
    a_break_sets_failed: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result.continuity_ok) |-> result.sequence_failed)
        else $error("break reported without sticky failure flag");

    // Input stall is raised only while the input register holds a word.
    a_stall_needs_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        pack_stall |-> s1_valid_reg)
        else $error("pack_stall raised with an empty input register");

    // An accepted pack is held in the input register on the next cycle.
    a_take_fills_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        pack_take |=> s1_valid_reg)
        else $error("accepted pack lost from the input register");

    // A word moving on always lands in the result register.
    a_advance_fills_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("word advanced but result register is empty");
`endif

endmodule

`default_nettype wire

/* rtl/tcbcc_decode.sv */
// ============================================================================
// tcbcc_decode: BCD pack decoder
// Turns the seven pack bytes into time, field and date values.
// ============================================================================
`default_nettype none

module tcbcc_decode
    import tcbcc_pkg::*;
(
    input  tcbcc_in_t  pack,
    input  logic [5:0] fps,
    output tcbcc_dec_t dec
);

    logic [7:0] hour_val;
    logic [7:0] minute_val;
    logic [7:0] second_val;
    logic [7:0] frame_val;
    logic [7:0] day_val;
    logic [7:0] month_val;
    logic [7:0] year_val;
    logic       field_mode;
    logic       field;

    assign hour_val   = bcd_value(pack.hour_byte,   HOUR_TENS_MASK);
    assign minute_val = bcd_value(pack.minute_byte, MINUTE_TENS_MASK);
    assign second_val = bcd_value(pack.second_byte, SECOND_TENS_MASK);
    assign frame_val  = bcd_value(pack.frame_byte,  FRAME_TENS_MASK);
    assign day_val    = bcd_value(pack.day_byte,    DAY_TENS_MASK);
    assign month_val  = bcd_value(pack.month_byte,  MONTH_TENS_MASK);
    assign year_val   = bcd_value(pack.year_byte,   YEAR_TENS_MASK);

    // At rates of 59 and up the field bit lives in the seconds byte, from 49 to
    // 58 in the hours byte; below 49 there is no field bit and it reads zero.
    always_comb
    begin
        field_mode = 1'b1;
        field      = 1'b0;
        if (fps >= FIELD_SECOND_FPS)
        begin
            field = pack.second_byte[FIELD_BIT_POS];
        end
        else if (fps >= FIELD_HOUR_FPS)
        begin
            field = pack.hour_byte[FIELD_BIT_POS];
        end
        else
        begin
            field_mode = 1'b0;
        end
    end

    always_comb
    begin
        dec.tm.hours   = hour_val[5:0];
        dec.tm.minutes = minute_val[6:0];
        dec.tm.seconds = second_val[6:0];
        dec.tm.frames  = frame_val[5:0];
        dec.drop_flag  = pack.frame_byte[DROP_FLAG_BIT];
        dec.field_bit  = field;
        if (field_mode)
        begin
            dec.full_frame = {frame_val[5:0], 1'b0} + {6'd0, field};
        end
        else
        begin
            dec.full_frame = {1'b0, frame_val[5:0]};
        end
        dec.day   = day_val[5:0];
        dec.month = month_val[4:0];
        dec.year  = year_val;
    end

endmodule

`default_nettype wire

/* rtl/tcbcc_check.sv */
// ============================================================================
// tcbcc_check: continuity tracker
// Holds the previous time, forms its successor and keeps the failure flag.
// ============================================================================
`default_nettype none

module tcbcc_check
    import tcbcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        start,
    input  tcbcc_time_t tm,
    input  logic [5:0]  fps,
    input  logic        drop_numbering,
    output logic        ok,
    output logic        failed
);

    logic [5:0] last_hour_reg;
    logic [6:0] last_minute_reg;
    logic [6:0] last_second_reg;
    logic [5:0] last_frame_reg;
    logic       have_last_reg;
    logic       failed_reg;
    logic       failed_next;

    logic [6:0] ef_inc;
    logic [7:0] es_inc;
    logic [7:0] em_inc;
    logic [6:0] eh_inc;
    logic       frame_wrap;
    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic [6:0] ef;
    logic [7:0] es;
    logic [7:0] em;
    logic [6:0] eh;
    logic       upper_eq;
    logic       plain_eq;
    logic       drop_eq;
    logic       match;

    assign ef_inc = {1'b0, last_frame_reg} + 7'd1;
    assign es_inc = {1'b0, last_second_reg} + 8'd1;
    assign em_inc = {1'b0, last_minute_reg} + 8'd1;
    assign eh_inc = {1'b0, last_hour_reg} + 7'd1;

    assign frame_wrap = ef_inc >= {1'b0, fps};
    assign sec_wrap   = es_inc > LAST_SECOND;
    assign min_wrap   = em_inc > LAST_MINUTE;
    assign hour_wrap  = eh_inc >= HOURS_PER_DAY;

    // Carry chain of the expected successor.
    assign ef = frame_wrap ? 7'd0 : ef_inc;
    assign es = frame_wrap ? (sec_wrap ? 8'd0 : es_inc) : {1'b0, last_second_reg};
    assign em = (frame_wrap && sec_wrap) ? (min_wrap ? 8'd0 : em_inc)
                                         : {1'b0, last_minute_reg};
    assign eh = (frame_wrap && sec_wrap && min_wrap) ? (hour_wrap ? 7'd0 : eh_inc)
                                                     : {1'b0, last_hour_reg};

    assign upper_eq = ({1'b0, tm.seconds} == es) && ({1'b0, tm.minutes} == em)
                   && ({1'b0, tm.hours} == eh);
    assign plain_eq = upper_eq && ({1'b0, tm.frames} == ef);

    // Drop-frame numbering skips frames 0 and 1 at minutes that are not
    // multiples of ten.
    assign drop_eq = drop_numbering && not_tenth(em[6:0]) && (es == 8'd0) && (ef == 7'd0)
                  && upper_eq && ({1'b0, tm.frames} == DROP_TO_FRAME);
    assign match   = plain_eq || drop_eq;

    always_comb
    begin
        ok          = 1'b1;
        failed_next = failed_reg;
        if (start)
        begin
            failed_next = 1'b0;
        end
        else if (have_last_reg && !match)
        begin
            ok          = 1'b0;
            failed_next = 1'b1;
        end
    end

    assign failed = failed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_hour_reg   <= '0;
            last_minute_reg <= '0;
            last_second_reg <= '0;
            last_frame_reg  <= '0;
            have_last_reg   <= 1'b0;
            failed_reg      <= 1'b0;
        end
        else if (fire)
        begin
            last_hour_reg   <= tm.hours;
            last_minute_reg <= tm.minutes;
            last_second_reg <= tm.seconds;
            last_frame_reg  <= tm.frames;
            have_last_reg   <= 1'b1;
            failed_reg      <= failed_next;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_timecode_bcd_continuity_checker_unit.sv */
// ============================================================================
// tb_timecode_bcd_continuity_checker_unit: self-checking timecode testbench
// Sends timecode packs through the valid/stall pack channel, predicts each
// decoded result word with an independent model of the decoder and the
// continuity checker, and compares every result word field by field.
// ============================================================================

module tb_timecode_bcd_continuity_checker_unit;

    import tcbcc_pkg::*;

    // Each random segment runs this many words under one register setting.
    localparam int unsigned SEGMENT_ITEMS = 50;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   pack_valid   = 1'b0;
    logic                   pack_stall;
    tcbcc_in_t              pack         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    tcbcc_out_t             result;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // Idle probabilities in percent for the pack source and the result sink.
    int unsigned sender_idle_pct   = 37;
    int unsigned receiver_idle_pct = 53;
    int unsigned mismatches        = 0;

    // Result words predicted for accepted packs, oldest first.
    tcbcc_out_t expected_decodes[$];

    // Predictor copy of the configuration registers, at their reset values.
    int unsigned rate_setting = 25;
    bit          drop_setting = 1'b0;

    // Predictor copy of the continuity history.
    int unsigned prev_hour   = 0;
    int unsigned prev_minute = 0;
    int unsigned prev_second = 0;
    int unsigned prev_frame  = 0;
    bit          prev_valid  = 1'b0;
    bit          break_seen  = 1'b0;

    // Running timecode that the random traffic walks forward.
    int unsigned cursor_hour;
    int unsigned cursor_minute;
    int unsigned cursor_second;
    int unsigned cursor_frame;

    timecode_bcd_continuity_checker_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pack_valid   (pack_valid),
        .pack_stall   (pack_stall),
        .pack         (pack),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Tens digit under the mask, times ten, plus the low nibble. Digits above
    // nine are taken at face value, just as the hardware does.
    function automatic int unsigned tens_units(input logic [7:0] b, input logic [7:0] mask);
        logic [7:0] masked;
        begin
            masked = b & mask;
            return int'(masked[7:4]) * 10 + int'(b[3:0]);
        end
    endfunction

    // Decodes one pack, judges it against the successor of the previous pack
    // and advances the history. The drop-frame retry only kicks in when the
    // plain successor misses and the successor lands on frame 0, second 0 of a
    // minute that is not a multiple of ten.
    function automatic tcbcc_out_t decode_and_check(input tcbcc_in_t w);
        int unsigned hr;
        int unsigned mi;
        int unsigned se;
        int unsigned fr;
        int unsigned eh;
        int unsigned em;
        int unsigned es;
        int unsigned ef;
        int unsigned full;
        int unsigned yr;
        int unsigned dy;
        int unsigned mo;
        bit          field;
        bit          ok;
        bit          eq;
        tcbcc_out_t  r;
        begin
            hr    = tens_units(w.hour_byte, HOUR_TENS_MASK);
            mi    = tens_units(w.minute_byte, MINUTE_TENS_MASK);
            se    = tens_units(w.second_byte, SECOND_TENS_MASK);
            fr    = tens_units(w.frame_byte, FRAME_TENS_MASK);
            dy    = tens_units(w.day_byte, DAY_TENS_MASK);
            mo    = tens_units(w.month_byte, MONTH_TENS_MASK);
            yr    = tens_units(w.year_byte, YEAR_TENS_MASK);
            field = 1'b0;
            full  = fr;
            ok    = 1'b1;

            if (rate_setting >= 59)
            begin
                field = w.second_byte[7];
                full  = fr * 2 + field;
            end
            else if (rate_setting >= 49)
            begin
                field = w.hour_byte[7];
                full  = fr * 2 + field;
            end

            if (w.new_sequence)
            begin
                break_seen = 1'b0;
            end
            else if (prev_valid)
            begin
                eh = prev_hour;
                em = prev_minute;
                es = prev_second;
                ef = prev_frame + 1;
                if (ef >= rate_setting)
                begin
                    ef = 0;
                    es = es + 1;
                    if (es > 59)
                    begin
                        es = 0;
                        em = em + 1;
                        if (em > 59)
                        begin
                            em = 0;
                            eh = eh + 1;
                            if (eh >= 24)
                                eh = 0;
                        end
                    end
                end
                eq = (fr == ef) && (se == es) && (mi == em) && (hr == eh);
                if (!eq && drop_setting && (em % 10) != 0 && es == 0 && ef == 0)
                begin
                    ef = 2;
                    eq = (fr == ef) && (se == es) && (mi == em) && (hr == eh);
                end
                if (!eq)
                begin
                    ok         = 1'b0;
                    break_seen = 1'b1;
                end
            end

            // Whatever the verdict, this pack is the reference for the next.
            prev_hour   = hr;
            prev_minute = mi;
            prev_second = se;
            prev_frame  = fr;
            prev_valid  = 1'b1;

            r.hours           = hr[5:0];
            r.minutes         = mi[6:0];
            r.seconds         = se[6:0];
            r.frames          = fr[5:0];
            r.drop_flag       = w.frame_byte[DROP_FLAG_BIT];
            r.field_bit       = field;
            r.full_frame      = full[6:0];
            r.day             = dy[5:0];
            r.month           = mo[4:0];
            r.year            = yr[7:0];
            r.continuity_ok   = ok;
            r.sequence_failed = break_seen;
            return r;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Pack construction
    // ------------------------------------------------------------------------

    function automatic logic [7:0] to_bcd(input int unsigned v);
        logic [7:0] r;
        begin
            r[7:4] = 4'(v / 10);
            r[3:0] = 4'(v % 10);
            return r;
        end
    endfunction

    // A fully random pack, sequence start bit included.
    function automatic tcbcc_in_t random_word();
        logic [63:0] bits;
        begin
            bits = {$urandom, $urandom};
            return bits[$bits(tcbcc_in_t)-1:0];
        end
    endfunction

    // A clean pack: flag bits clear, a fixed valid date.
    function automatic tcbcc_in_t timecode_word(input bit restart, input int unsigned h,
                                                input int unsigned m, input int unsigned s,
                                                input int unsigned f);
        tcbcc_in_t w;
        begin
            w.new_sequence = restart;
            w.frame_byte   = to_bcd(f) & 8'h3F;
            w.second_byte  = to_bcd(s) & 8'h7F;
            w.minute_byte  = to_bcd(m) & 8'h7F;
            w.hour_byte    = to_bcd(h) & 8'h3F;
            w.day_byte     = 8'h28;
            w.month_byte   = 8'h02;
            w.year_byte    = 8'h24;
            return w;
        end
    endfunction

    // The cursor as a pack. The bits that the BCD masks ignore, the drop flag
    // and the field bits get random values, and so does the date, so the
    // continuity of a well-formed run is not disturbed.
    function automatic tcbcc_in_t cursor_word(input bit restart);
        tcbcc_in_t w;
        begin
            w = timecode_word(restart, cursor_hour, cursor_minute, cursor_second, cursor_frame);
            w.frame_byte[7:6]  = 2'($urandom_range(3));
            w.second_byte[7]   = 1'($urandom_range(1));
            w.minute_byte[7]   = 1'($urandom_range(1));
            w.hour_byte[7:6]   = 2'($urandom_range(3));
            w.day_byte         = 8'($urandom);
            w.month_byte       = 8'($urandom);
            w.year_byte        = 8'($urandom);
            return w;
        end
    endfunction

    // Random starting point, biased toward the frame, second, minute and hour
    // wraps and toward the minutes just ahead of a tenth minute, where drop numbering skips no frames.
    task automatic start_cursor();
        int unsigned last_frame;
        begin
            cursor_hour   = ($urandom_range(3) == 0) ? 23 : $urandom_range(23);
            cursor_minute = ($urandom_range(1) == 0) ? $urandom_range(5) * 10 + 9
                                                     : $urandom_range(59);
            cursor_second = ($urandom_range(1) == 0) ? 59 : $urandom_range(59);
            if (rate_setting == 0)
            begin
                cursor_frame = 0;
            end
            else
            begin
                last_frame   = rate_setting - 1;
                cursor_frame = last_frame - $urandom_range(last_frame < 3 ? last_frame : 3);
            end
            // Frames of 40 and up cannot be carried by the two-bit tens digit.
            if (cursor_frame > 39)
                cursor_frame = $urandom_range(39);
        end
    endtask

    // Steps the cursor to its successor. With drop numbering on, the skip to
    // frame 2 is taken most of the time; plain frame 0 is accepted as well.
    task automatic advance_cursor();
        begin
            cursor_frame = cursor_frame + 1;
            if (cursor_frame >= rate_setting)
            begin
                cursor_frame  = 0;
                cursor_second = cursor_second + 1;
                if (cursor_second > 59)
                begin
                    cursor_second = 0;
                    cursor_minute = cursor_minute + 1;
                    if (cursor_minute > 59)
                    begin
                        cursor_minute = 0;
                        cursor_hour   = cursor_hour + 1;
                        if (cursor_hour >= 24)
                            cursor_hour = 0;
                    end
                end
            end
            if (drop_setting && cursor_minute % 10 != 0 && cursor_second == 0
                && cursor_frame == 0 && $urandom_range(3) != 0)
                cursor_frame = 2;
        end
    endtask

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Presents one word and returns at the edge that takes it. An optional
    // idle gap comes first, with junk on the payload while valid is low.
    // Stall is sampled on the falling edge: all inputs move on the rising
    // edge, so the value there is the one the next rising edge sees.
    task automatic send_word(input tcbcc_in_t w);
        bit taken;
        begin
            if ($urandom_range(99) < sender_idle_pct)
            begin
                pack_valid <= 1'b0;
                pack       <= random_word();
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            pack       <= w;
            pack_valid <= 1'b1;
            do
            begin
                @(negedge clk);
                taken = !pack_stall;
                @(posedge clk);
            end
            while (!taken);
            expected_decodes.push_back(decode_and_check(w));
        end
    endtask

    // Stops the source until every predicted word has been delivered.
    task automatic hold_until_drained();
        begin
            pack_valid <= 1'b0;
            @(posedge clk);
            while (expected_decodes.size() != 0)
                @(posedge clk);
        end
    endtask

    // Drains and then waits out the pipeline registers so that nothing is in
    // flight when a register changes.
    task automatic settle_pipeline();
        begin
            hold_until_drained();
            repeat (3) @(posedge clk);
        end
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            cfg_write <= 1'b0;
            if (idx == CFG_FRAMES_PER_SECOND)
                rate_setting = value;
            else
                drop_setting = value[0];
            @(posedge clk);
        end
    endtask

    task automatic apply_settings(input int unsigned rate, input bit drop);
        begin
            settle_pipeline();
            write_register(CFG_FRAMES_PER_SECOND, rate[CFG_DATA_W-1:0]);
            write_register(CFG_DROP_NUMBERING, {{(CFG_DATA_W-1){1'b0}}, drop});
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The sink stalls at random, per cycle, at the current idle rate.
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < receiver_idle_pct);

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got)
            begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        end
    endtask

    // A result word is taken at the next rising edge when valid is high and
    // stall is low here; both are stable since the previous rising edge.
    always @(negedge clk)
    begin : result_monitor
        tcbcc_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_decodes.size() == 0)
            begin
                mismatches++;
                $error("result word arrived with no pack waiting for it");
            end
            else
            begin
                want = expected_decodes.pop_front();
                check_field("hours", want.hours, result.hours);
                check_field("minutes", want.minutes, result.minutes);
                check_field("seconds", want.seconds, result.seconds);
                check_field("frames", want.frames, result.frames);
                check_field("drop_flag", want.drop_flag, result.drop_flag);
                check_field("field_bit", want.field_bit, result.field_bit);
                check_field("full_frame", want.full_frame, result.full_frame);
                check_field("day", want.day, result.day);
                check_field("month", want.month, result.month);
                check_field("year", want.year, result.year);
                check_field("continuity_ok", want.continuity_ok, result.continuity_ok);
                check_field("sequence_failed", want.sequence_failed,
                            result.sequence_failed);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: 25 frames per second, no drop numbering. The very first
    // pack has no predecessor and must pass even without a sequence start.
    task automatic test_reset_defaults();
        tcbcc_in_t w;
        begin
            send_word(timecode_word(1'b0, 23, 59, 59, 24));
            // Full wrap of frame, second, minute and hour into midnight.
            send_word(timecode_word(1'b0, 0, 0, 0, 0));
            w = timecode_word(1'b0, 0, 0, 0, 1);
            w.frame_byte[DROP_FLAG_BIT] = 1'b1;
            send_word(w);
            // A skipped frame is a break; the pack after it is judged against
            // the broken one and passes, while the failure stays sticky.
            send_word(timecode_word(1'b0, 0, 0, 0, 3));
            send_word(timecode_word(1'b0, 0, 0, 0, 4));
            send_word(timecode_word(1'b1, 12, 34, 56, 10));
            // Every bit set: all units digits out of range, decoded as they stand.
            w = '1;
            w.new_sequence = 1'b0;
            send_word(w);
            w = '0;
            send_word(w);
        end
    endtask

    task automatic test_drop_numbering();
        begin
            apply_settings(30, 1'b1);
            send_word(timecode_word(1'b1, 0, 0, 59, 29));
            send_word(timecode_word(1'b0, 0, 1, 0, 2));
            // At a tenth minute the skip is not allowed.
            send_word(timecode_word(1'b1, 0, 9, 59, 29));
            send_word(timecode_word(1'b0, 0, 10, 0, 2));
            // Frame 0 at a skip minute still matches the plain successor.
            send_word(timecode_word(1'b1, 0, 1, 59, 29));
            send_word(timecode_word(1'b0, 0, 2, 0, 0));
        end
    endtask

    // The field bit comes from the hour byte from 49 to 58 frames per second
    // and from the second byte at 59 and up.
    task automatic test_field_modes();
        tcbcc_in_t w;
        begin
            apply_settings(49, 1'b0);
            w = timecode_word(1'b1, 1, 2, 3, 24);
            w.hour_byte[FIELD_BIT_POS] = 1'b1;
            send_word(w);
            apply_settings(58, 1'b0);
            w = timecode_word(1'b1, 1, 2, 3, 25);
            w.hour_byte[FIELD_BIT_POS]   = 1'b1;
            w.second_byte[FIELD_BIT_POS] = 1'b1;
            send_word(w);
            apply_settings(59, 1'b0);
            w = timecode_word(1'b1, 1, 2, 3, 26);
            w.second_byte[FIELD_BIT_POS] = 1'b1;
            send_word(w);
            apply_settings(60, 1'b1);
            w = timecode_word(1'b1, 1, 2, 3, 39);
            w.second_byte[FIELD_BIT_POS] = 1'b1;
            send_word(w);
            send_word(timecode_word(1'b0, 1, 2, 3, 0));
        end
    endtask

    // A rate of zero wraps the frame on every pack, and so does a rate of one.
    task automatic test_rate_extremes();
        begin
            apply_settings(0, 1'b0);
            send_word(timecode_word(1'b1, 0, 0, 0, 5));
            send_word(timecode_word(1'b0, 0, 0, 1, 0));
            send_word(timecode_word(1'b0, 0, 0, 2, 0));
            apply_settings(1, 1'b0);
            send_word(timecode_word(1'b1, 23, 59, 59, 0));
            send_word(timecode_word(1'b0, 0, 0, 0, 0));
        end
    endtask

    function automatic int unsigned pick_rate();
        begin
            case ($urandom_range(9))
                0:       return 1;
                1:       return 60;
                2:       return 50;
                3:       return 59;
                4:       return 30;
                default: return $urandom_range(10, 40);
            endcase
        end
    endfunction

    // Mostly well-formed runs from random starting points, with sequence
    // restarts, jumps in the timecode and fully random packs mixed in. Each
    // segment begins with fresh register values.
    task automatic test_random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned roll;
        tcbcc_in_t   w;
        begin
            sent = 0;
            while (sent < count)
            begin
                if (sent % SEGMENT_ITEMS == 0)
                begin
                    apply_settings(pick_rate(), $urandom_range(1));
                    start_cursor();
                    send_word(cursor_word(1'b1));
                end
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 3)
                    begin
                        start_cursor();
                        send_word(cursor_word(1'b1));
                    end
                    else if (roll < 9)
                    begin
                        w = random_word();
                        send_word(w);
                    end
                    else if (roll < 13)
                    begin
                        start_cursor();
                        send_word(cursor_word(1'b0));
                    end
                    else
                    begin
                        advance_cursor();
                        send_word(cursor_word(1'b0));
                    end
                    // Now and then the source waits for the sink to catch up.
                    if ($urandom_range(99) == 0)
                        hold_until_drained();
                end
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_drop_numbering();
        test_field_modes();
        test_rate_extremes();

        test_random_traffic(200);
        sender_idle_pct   = 53;
        receiver_idle_pct = 37;
        test_random_traffic(200);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(200);

        hold_until_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
